>>> sv/id3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id3_pkg
// Shared constants and types for the ID3v2 tag header parser.
// ----------------------------------------------------------------------------
package id3_pkg;

  localparam logic [7:0] MAGIC_0     = 8'h49;  // 'I'
  localparam logic [7:0] MAGIC_1     = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC_2     = 8'h33;  // '3'
  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] BYTE_00     = 8'h00;
  localparam logic [7:0] MAJOR_MIN   = 8'd2;
  localparam logic [7:0] MAJOR_MAX   = 8'd4;
  localparam logic [7:0] MAJOR_V3    = 8'd3;
  localparam int         UNSYNC_BIT  = 7;
  localparam int         SIZE_W      = 28;

  localparam logic [3:0] IDX_MAGIC_0 = 4'd0;
  localparam logic [3:0] IDX_MAGIC_1 = 4'd1;
  localparam logic [3:0] IDX_MAGIC_2 = 4'd2;
  localparam logic [3:0] IDX_MAJOR   = 4'd3;
  localparam logic [3:0] IDX_REV     = 4'd4;
  localparam logic [3:0] IDX_FLAGS   = 4'd5;
  localparam logic [3:0] IDX_LAST    = 4'd9;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        out_byte;
    logic              byte_present;
    logic              header_valid;
    logic [7:0]        major_version;
    logic [7:0]        revision;
    logic [7:0]        header_flags;
    logic [SIZE_W-1:0] tag_size;
    logic              unsync_applied;
    logic              end_of_tag;
  } result_t;

endpackage
`default_nettype wire

>>> sv/id3v2_header_unsync_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id3v2_header_unsync_parser
// Parses the 10-byte ID3v2 header, reports it, then streams body bytes with
// FF 00 unsynchronisation removal for version 3 tags with the unsync flag set.
// ----------------------------------------------------------------------------
// A byte passes the input register, then the result register; only the last
//   header byte (as the header report) and body bytes produce a result.
// Throughput: 1 byte per cycle unless output stalls; single-pass state update.
// Reset: synchronous active-low rst_n clears the parser state and both
//   handshake stages; the block is ready on the first cycle after reset.
module id3v2_header_unsync_parser
  import id3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] start_of_tag
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [7:0] out_byte, [8] byte_present,
                                       // [9] header_valid, [17:10] major_version,
                                       // [25:18] revision, [33:26] header_flags,
                                       // [61:34] tag_size, [62] unsync_applied,
                                       // [63] zero
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast   // end_of_tag
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              magic_ok_r, magic_ok_nxt;
  logic [7:0]        major_r, major_nxt;
  logic [7:0]        rev_r, rev_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic              prev_ff_r, prev_ff_nxt;
  logic              unsync_r, unsync_nxt;

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_start_r;

  logic              out_valid_r;
  result_t           res_r, res_nxt;
  logic              res_hit;

  logic              advance;
  logic              fire;
  logic              hdr_ok;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    phase_nxt    = in_start_r ? PH_HEADER : phase_r;
    idx_nxt      = in_start_r ? IDX_MAGIC_0 : idx_r;
    magic_ok_nxt = in_start_r ? 1'b1 : magic_ok_r;
    major_nxt    = major_r;
    rev_nxt      = rev_r;
    flags_nxt    = flags_r;
    size_nxt     = in_start_r ? '0 : size_r;
    left_nxt     = left_r;
    prev_ff_nxt  = in_start_r ? 1'b0 : prev_ff_r;
    unsync_nxt   = in_start_r ? 1'b0 : unsync_r;
    res_nxt      = '0;
    res_hit      = 1'b0;
    hdr_ok       = 1'b0;

    case (phase_nxt)
      PH_HEADER: begin
        case (idx_nxt)
          IDX_MAGIC_0: magic_ok_nxt = magic_ok_nxt && (in_byte_r == MAGIC_0);
          IDX_MAGIC_1: magic_ok_nxt = magic_ok_nxt && (in_byte_r == MAGIC_1);
          IDX_MAGIC_2: magic_ok_nxt = magic_ok_nxt && (in_byte_r == MAGIC_2);
          IDX_MAJOR:   major_nxt = in_byte_r;
          IDX_REV:     rev_nxt = in_byte_r;
          IDX_FLAGS:   flags_nxt = in_byte_r;
          default:     size_nxt = {size_nxt[SIZE_W-8:0], in_byte_r[6:0]};
        endcase
        if (idx_nxt == IDX_LAST) begin
          hdr_ok = magic_ok_nxt && (size_nxt != '0) &&
                   (major_nxt >= MAJOR_MIN) && (major_nxt <= MAJOR_MAX);
          unsync_nxt             = hdr_ok && (major_nxt == MAJOR_V3) &&
                                   flags_nxt[UNSYNC_BIT];
          res_hit                = 1'b1;
          res_nxt.kind           = KIND_HEADER;
          res_nxt.header_valid   = hdr_ok;
          res_nxt.major_version  = major_nxt;
          res_nxt.revision       = rev_nxt;
          res_nxt.header_flags   = flags_nxt;
          res_nxt.tag_size       = size_nxt;
          res_nxt.unsync_applied = unsync_nxt;
          res_nxt.end_of_tag     = !hdr_ok;
          idx_nxt                = IDX_MAGIC_0;
          prev_ff_nxt            = 1'b0;
          left_nxt               = hdr_ok ? size_nxt : '0;
          phase_nxt              = hdr_ok ? PH_BODY : PH_DONE;
        end else begin
          idx_nxt = idx_nxt + 4'd1;
        end
      end
      PH_BODY: begin
        res_hit                = 1'b1;
        res_nxt.kind           = KIND_BODY;
        res_nxt.out_byte       = in_byte_r;
        res_nxt.byte_present   = !(unsync_nxt && prev_ff_nxt && (in_byte_r == BYTE_00));
        res_nxt.unsync_applied = unsync_nxt;
        res_nxt.end_of_tag     = (left_nxt == SIZE_W'(1));
        prev_ff_nxt            = (in_byte_r == BYTE_FF);
        left_nxt               = left_nxt - SIZE_W'(1);
        if (left_nxt == '0) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      magic_ok_r  <= 1'b0;
      major_r     <= '0;
      rev_r       <= '0;
      flags_r     <= '0;
      size_r      <= '0;
      left_r      <= '0;
      prev_ff_r   <= 1'b0;
      unsync_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= fire && res_hit;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        idx_r      <= idx_nxt;
        magic_ok_r <= magic_ok_nxt;
        major_r    <= major_nxt;
        rev_r      <= rev_nxt;
        flags_r    <= flags_nxt;
        size_r     <= size_nxt;
        left_r     <= left_nxt;
        prev_ff_r  <= prev_ff_nxt;
        unsync_r   <= unsync_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
    if (fire && res_hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.end_of_tag;
  assign out_tdata  = {1'b0, res_r.unsync_applied, res_r.tag_size, res_r.header_flags,
                       res_r.revision, res_r.major_version, res_r.header_valid,
                       res_r.byte_present, res_r.out_byte};

  // header reports never carry a body byte
  a_hdr_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == KIND_HEADER) |-> !res_r.byte_present)
    else $error("header report flags a body byte");

  // an invalid header closes the tag and never enables unsync
  a_bad_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == KIND_HEADER && !res_r.header_valid) |->
      (res_r.end_of_tag && !res_r.unsync_applied))
    else $error("invalid header report not closing tag");

  // without unsync every body byte is passed
  a_body_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == KIND_BODY && !res_r.unsync_applied) |->
      res_r.byte_present)
    else $error("body byte dropped without unsync");

  // body phase always has bytes left to count
  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (left_r != '0))
    else $error("body phase with zero bytes left");

  // header index stays within the header length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("header index out of range");

endmodule
`default_nettype wire
